// ----- design/afe_pkg.sv -----
// Package for the audio fade envelope: beat structs, command and register codes,
// fixed-point constants of the sine-squared table. No dependencies.
package afe_pkg;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    FALL_OFF  = 2'd0,
    FALL_WAIT = 2'd1,
    FALL_STEP = 2'd2
  } fall_phase_t;

  localparam logic REG_BASE_GAIN = 1'b0;
  localparam logic REG_LEVEL     = 1'b1;

  localparam logic [15:0] BASE_GAIN_RST = 16'd16384;
  localparam logic [15:0] LEVEL_RST     = 16'd32768;
  localparam logic [15:0] FACTOR_MAX    = 16'd32768;

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] SQ_ROUND    = 64'd1 << 44;
  localparam logic [63:0] TAYLOR_DIV [6] = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] duration_ms;
    logic [15:0] fade_ms;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] gain;
    logic [15:0] fade_factor;
    logic        busy_res;
    logic        accepted;
    logic        finished;
  } out_beat_t;

endpackage

// ----- design/audio_fade_envelope_top.sv -----
// Audio fade envelope top level: sequencer, step divider, shared gain multiplier.
// Depends on afe_pkg.
//
// Each input beat (tick, start or stop) yields exactly one result beat carrying
// gain, envelope factor and status flags. A tick, a stop or a refused start goes
// from acceptance through a command state, two passes through the shared 32x16
// multiplier, a saturate state and the idle state to the next acceptance; an
// accepted start adds one more multiplier pass that divides the capped fade by
// FADE_STEPS through a reciprocal and a state for the fade-out delay subtract.
// A result held back by out_ready keeps the sequencer in its final state.
// in_ready is high only while the sequencer is idle; one finished result may wait
// in the output register while the next beat is taken. base_gain is at APB
// address 0 and listener_level at address 4.
module audio_fade_envelope_top #(
  parameter int FADE_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  afe_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output afe_pkg::out_beat_t out_data,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  localparam int SW = (FADE_STEPS > 1) ? $clog2(FADE_STEPS) : 1;
  localparam logic [SW-1:0] LAST_STEP = SW'(FADE_STEPS - 1);
  // exact floor division of any 16-bit value by FADE_STEPS
  localparam int RSH = 16 + $clog2(FADE_STEPS);
  localparam logic [31:0] RECIP =
    32'(((64'd1 << RSH) + 64'(FADE_STEPS - 1)) / 64'(FADE_STEPS));

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_EXEC = 7'b0000010,
    ST_DIV  = 7'b0000100,
    ST_T0   = 7'b0001000,
    ST_MUL1 = 7'b0010000,
    ST_MUL2 = 7'b0100000,
    ST_FIN  = 7'b1000000
  } state_t;

  // sine-squared envelope table, built at elaboration
  logic [15:0] rom [FADE_STEPS];

  for (genvar gi = 0; gi < FADE_STEPS; gi++) begin : g_rom
    localparam logic [63:0] X   = (afe_pkg::HALF_PI_Q30 * 64'(gi)) / (FADE_STEPS - 1);
    localparam logic [63:0] X2  = (X * X) >> 30;
    localparam logic [63:0] D1  = ((X2 * afe_pkg::Q30_ONE) >> 30) / afe_pkg::TAYLOR_DIV[0];
    localparam logic [63:0] T1  = (D1 >= afe_pkg::Q30_ONE) ? 64'd0 : afe_pkg::Q30_ONE - D1;
    localparam logic [63:0] D2  = ((X2 * T1) >> 30) / afe_pkg::TAYLOR_DIV[1];
    localparam logic [63:0] T2  = (D2 >= afe_pkg::Q30_ONE) ? 64'd0 : afe_pkg::Q30_ONE - D2;
    localparam logic [63:0] D3  = ((X2 * T2) >> 30) / afe_pkg::TAYLOR_DIV[2];
    localparam logic [63:0] T3  = (D3 >= afe_pkg::Q30_ONE) ? 64'd0 : afe_pkg::Q30_ONE - D3;
    localparam logic [63:0] D4  = ((X2 * T3) >> 30) / afe_pkg::TAYLOR_DIV[3];
    localparam logic [63:0] T4  = (D4 >= afe_pkg::Q30_ONE) ? 64'd0 : afe_pkg::Q30_ONE - D4;
    localparam logic [63:0] D5  = ((X2 * T4) >> 30) / afe_pkg::TAYLOR_DIV[4];
    localparam logic [63:0] T5  = (D5 >= afe_pkg::Q30_ONE) ? 64'd0 : afe_pkg::Q30_ONE - D5;
    localparam logic [63:0] D6  = ((X2 * T5) >> 30) / afe_pkg::TAYLOR_DIV[5];
    localparam logic [63:0] T6  = (D6 >= afe_pkg::Q30_ONE) ? 64'd0 : afe_pkg::Q30_ONE - D6;
    localparam logic [63:0] S0  = (X * T6) >> 30;
    localparam logic [63:0] S   = (S0 > afe_pkg::Q30_ONE) ? afe_pkg::Q30_ONE : S0;
    localparam logic [63:0] SQ0 = (S * S + afe_pkg::SQ_ROUND) >> 45;
    localparam logic [63:0] SQ  = (SQ0 > 64'(afe_pkg::FACTOR_MAX)) ?
                                  64'(afe_pkg::FACTOR_MAX) : SQ0;
    assign rom[gi] = SQ[15:0];
  end

  state_t                 state_r, state_nxt;
  afe_pkg::in_beat_t      in_r;
  logic [15:0]            base_gain_r, level_r;
  logic                   playing_r, playing_nxt;
  logic [15:0]            factor_r, factor_nxt;
  logic [15:0]            capped_r, capped_nxt;
  logic [15:0]            period_r, period_nxt;
  logic                   rise_on_r, rise_on_nxt;
  logic [SW-1:0]          rise_step_r, rise_step_nxt;
  logic [15:0]            rise_wait_r, rise_wait_nxt;
  afe_pkg::fall_phase_t   fall_phase_r, fall_phase_nxt;
  logic [SW-1:0]          fall_step_r, fall_step_nxt;
  logic [31:0]            fall_wait_r, fall_wait_nxt;
  logic                   acc_r, acc_nxt;
  logic                   fin_r, fin_nxt;
  logic [47:0]            prod_r, prod_nxt;
  logic                   out_valid_r;
  afe_pkg::out_beat_t     out_data_r;

  logic [31:0]            mul_a;
  logic [15:0]            mul_b;
  logic [47:0]            mul_p;
  logic [15:0]            div_q;
  logic [31:0]            cap;
  logic [31:0]            t0;
  logic                   out_free;
  logic                   cfg_wr;

  assign in_ready   = (state_r == ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign out_free   = !out_valid_r || out_ready;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == afe_pkg::REG_LEVEL) ? {16'd0, level_r} :
                                                              {16'd0, base_gain_r};

  // shared multiplier
  always_comb begin
    if (state_r == ST_DIV) begin
      mul_a = RECIP;
      mul_b = capped_r;
    end else if (state_r == ST_MUL2) begin
      mul_a = prod_r[31:0];
      mul_b = level_r;
    end else begin
      mul_a = {16'd0, base_gain_r};
      mul_b = factor_r;
    end
  end
  assign mul_p = 48'(mul_a) * 48'(mul_b);

  assign div_q   = mul_p[RSH +: 16];
  assign cap     = (in_r.duration_ms >= 32'd2) ? (in_r.duration_ms >> 1) : 32'd1;
  assign t0      = (in_r.duration_ms > 32'(capped_r)) ? in_r.duration_ms - 32'(capped_r)
                                                      : 32'd0;

  always_comb begin
    state_nxt      = state_r;
    playing_nxt    = playing_r;
    factor_nxt     = factor_r;
    capped_nxt     = capped_r;
    period_nxt     = period_r;
    rise_on_nxt    = rise_on_r;
    rise_step_nxt  = rise_step_r;
    rise_wait_nxt  = rise_wait_r;
    fall_phase_nxt = fall_phase_r;
    fall_step_nxt  = fall_step_r;
    fall_wait_nxt  = fall_wait_r;
    acc_nxt        = acc_r;
    fin_nxt        = fin_r;
    prod_nxt       = prod_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        acc_nxt   = 1'b0;
        fin_nxt   = 1'b0;
        state_nxt = ST_MUL1;
        case (in_r.command)
          afe_pkg::CMD_TICK: begin
            if (rise_on_r) begin
              if (rise_wait_r > 16'd1) begin
                rise_wait_nxt = rise_wait_r - 16'd1;
              end else begin
                factor_nxt = rom[rise_step_r];
                if (rise_step_r == LAST_STEP) begin
                  rise_on_nxt   = 1'b0;
                  rise_step_nxt = '0;
                  rise_wait_nxt = 16'd0;
                end else begin
                  rise_step_nxt = rise_step_r + SW'(1);
                  rise_wait_nxt = period_r;
                end
              end
            end
            case (fall_phase_r)
              afe_pkg::FALL_WAIT: begin
                if (fall_wait_r > 32'd1) begin
                  fall_wait_nxt = fall_wait_r - 32'd1;
                end else begin
                  fall_phase_nxt = afe_pkg::FALL_STEP;
                  fall_step_nxt  = '0;
                  fall_wait_nxt  = 32'(period_r);
                end
              end
              afe_pkg::FALL_STEP: begin
                if (fall_wait_r > 32'd1) begin
                  fall_wait_nxt = fall_wait_r - 32'd1;
                end else if (fall_step_r == LAST_STEP) begin
                  playing_nxt    = 1'b0;
                  factor_nxt     = 16'd0;
                  rise_on_nxt    = 1'b0;
                  rise_step_nxt  = '0;
                  rise_wait_nxt  = 16'd0;
                  fall_phase_nxt = afe_pkg::FALL_OFF;
                  fall_step_nxt  = '0;
                  fall_wait_nxt  = 32'd0;
                  fin_nxt        = 1'b1;
                end else begin
                  factor_nxt    = rom[LAST_STEP - fall_step_r];
                  fall_step_nxt = fall_step_r + SW'(1);
                  fall_wait_nxt = 32'(period_r);
                end
              end
              default: ;
            endcase
          end
          afe_pkg::CMD_START: begin
            if (!playing_r) begin
              playing_nxt   = 1'b1;
              acc_nxt       = 1'b1;
              capped_nxt    = (32'(in_r.fade_ms) > cap) ? cap[15:0] : in_r.fade_ms;
              factor_nxt    = 16'd0;
              rise_on_nxt   = 1'b1;
              rise_step_nxt = '0;
              fall_step_nxt = '0;
              state_nxt     = ST_DIV;
            end
          end
          afe_pkg::CMD_STOP: begin
            rise_on_nxt    = 1'b0;
            rise_step_nxt  = '0;
            rise_wait_nxt  = 16'd0;
            fall_phase_nxt = afe_pkg::FALL_STEP;
            fall_step_nxt  = '0;
            fall_wait_nxt  = 32'(period_r);
          end
          default: ;
        endcase
      end
      ST_DIV: begin
        period_nxt    = (div_q == 16'd0) ? 16'd1 : div_q;
        rise_wait_nxt = (div_q == 16'd0) ? 16'd1 : div_q;
        state_nxt     = ST_T0;
      end
      ST_T0: begin
        if (t0 == 32'd0) begin
          fall_phase_nxt = afe_pkg::FALL_STEP;
          fall_wait_nxt  = 32'(period_r);
        end else begin
          fall_phase_nxt = afe_pkg::FALL_WAIT;
          fall_wait_nxt  = t0;
        end
        state_nxt = ST_MUL1;
      end
      ST_MUL1: begin
        prod_nxt  = mul_p;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        prod_nxt  = mul_p;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      base_gain_r  <= afe_pkg::BASE_GAIN_RST;
      level_r      <= afe_pkg::LEVEL_RST;
      playing_r    <= 1'b0;
      factor_r     <= 16'd0;
      capped_r     <= 16'd0;
      period_r     <= 16'd1;
      rise_on_r    <= 1'b0;
      rise_step_r  <= '0;
      rise_wait_r  <= 16'd0;
      fall_phase_r <= afe_pkg::FALL_OFF;
      fall_step_r  <= '0;
      fall_wait_r  <= 32'd0;
      acc_r        <= 1'b0;
      fin_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      playing_r    <= playing_nxt;
      factor_r     <= factor_nxt;
      capped_r     <= capped_nxt;
      period_r     <= period_nxt;
      rise_on_r    <= rise_on_nxt;
      rise_step_r  <= rise_step_nxt;
      rise_wait_r  <= rise_wait_nxt;
      fall_phase_r <= fall_phase_nxt;
      fall_step_r  <= fall_step_nxt;
      fall_wait_r  <= fall_wait_nxt;
      acc_r        <= acc_nxt;
      fin_r        <= fin_nxt;
      if (cfg_wr) begin
        if (cfg_paddr[2] == afe_pkg::REG_LEVEL) begin
          level_r <= cfg_pwdata[15:0];
        end else begin
          base_gain_r <= cfg_pwdata[15:0];
        end
      end
      if (state_r == ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (state_r == ST_FIN && out_free) begin
      out_data_r.gain        <= (prod_r[47:46] != 2'b00) ? 16'hFFFF : prod_r[45:30];
      out_data_r.fade_factor <= factor_r;
      out_data_r.busy_res    <= playing_r;
      out_data_r.accepted    <= acc_r;
      out_data_r.finished    <= fin_r;
    end
  end

`ifndef ASSERT_OFF
  a_factor_range: assert property (@(posedge clk) disable iff (!rst_n)
    factor_r <= afe_pkg::FACTOR_MAX)
    else $error("envelope factor above unity");

  a_new_beat_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result beat raised outside final state");

  a_finished_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.finished |-> !out_data_r.busy_res &&
      out_data_r.fade_factor == 16'd0 && !out_data_r.accepted)
    else $error("finished beat with playback still active");

  a_accepted_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.accepted |-> out_data_r.busy_res)
    else $error("accepted start without busy");
`endif

endmodule
